FILE: hdl/lsfe_pkg.sv
// Shared constants and types for the LED strip frame encoder.
`timescale 1ns / 1ps

package lsfe_pkg;

  // LEDs in one frame (1..255)
  localparam int unsigned NUM_LEDS = 3;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BRIGHT_W = 5;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned PHASE_W  = 4;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [BRIGHT_W-1:0] bright_t;
  typedef logic [INDEX_W-1:0]  led_index_t;
  typedef logic [PHASE_W-1:0]  phase_t;

  localparam byte_t     START_BYTE  = 8'h00;
  localparam byte_t     END_BYTE    = 8'hFF;
  localparam logic [2:0] HEADER_BITS = 3'b111;
  localparam bright_t   BRIGHT_RST  = 5'd1;

  // Phase = {segment, byte within segment}; each segment is a 4-byte burst
  localparam logic [1:0] SEG_START = 2'd0;
  localparam logic [1:0] SEG_LED   = 2'd1;
  localparam logic [1:0] SEG_END   = 2'd2;

  localparam logic [1:0] LED_HDR   = 2'd0;
  localparam logic [1:0] LED_BLUE  = 2'd1;
  localparam logic [1:0] LED_GREEN = 2'd2;
  localparam logic [1:0] LED_RED   = 2'd3;

  localparam phase_t PH_FIRST_START = {SEG_START, 2'd0};
  localparam phase_t PH_FIRST_LED   = {SEG_LED, LED_HDR};
  localparam phase_t PH_LAST_LED    = {SEG_LED, LED_RED};
  localparam phase_t PH_LAST_END    = {SEG_END, 2'd3};

endpackage

FILE: hdl/led_strip_frame_encoder_core.sv
// Path: an accepted LED is loaded into the item register, and its bytes pass through the output register to out_*.
// Throughput: one byte per cycle on the output port while out_stall is low; an LED is 4 bytes,
//   8 when it opens or closes a frame (start or end burst) and 12 when it does both.
// The next LED is taken in the same cycle its predecessor's last byte enters the output reg.
// Reset (rst_n low, synchronous): no item held, output empty, LED count 0, brightness 1.
`timescale 1ns / 1ps

module led_strip_frame_encoder_core (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration: global brightness
  input  logic                   cfg_wr_en,
  input  lsfe_pkg::bright_t      cfg_wr_data,
  // LED color transactions
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lsfe_pkg::byte_t        in_red,
  input  lsfe_pkg::byte_t        in_green,
  input  lsfe_pkg::byte_t        in_blue,
  // byte stream transactions
  output logic                   out_valid,
  input  logic                   out_stall,
  output lsfe_pkg::byte_t        out_byte,
  output logic                   out_last_of_item,
  output logic                   out_frame_end
);
  import lsfe_pkg::*;

  // Configuration register
  bright_t bright_r;

  // Item register: the LED being serialized and where we are in its byte sequence
  logic       item_vld_r, item_vld_nxt;
  byte_t      red_r, green_r, blue_r;
  logic       ends_r;                  // this LED closes the frame
  phase_t     phase_r, phase_nxt;

  // Frame position
  led_index_t led_idx_r, led_idx_nxt;

  // Output register
  logic       out_vld_r, out_vld_nxt;
  byte_t      out_byte_r;
  logic       out_last_r, out_fend_r;

  // Datapath signals
  logic       out_ready;     // output register can take a byte this cycle
  logic       item_adv;      // a byte moves from item register to output register
  logic       item_last;     // current phase is the item's final byte
  logic       in_acc;
  byte_t      cur_byte;
  logic       cur_fend;
  logic [INDEX_W:0] led_next;  // one extra bit so 255+1 does not wrap
  logic       acc_ends;

  assign out_ready = !out_vld_r || !out_stall;
  assign item_adv  = item_vld_r && out_ready;
  assign item_last = ends_r ? (phase_r == PH_LAST_END) : (phase_r == PH_LAST_LED);
  assign cur_fend  = (phase_r == PH_LAST_END);

  // Free when empty, or when the last byte leaves this cycle
  assign in_stall = item_vld_r && !(item_adv && item_last);
  assign in_acc   = in_valid && !in_stall;

  assign led_next = {1'b0, led_idx_r} + {{INDEX_W{1'b0}}, 1'b1};
  assign acc_ends = (led_next >= (INDEX_W+1)'(NUM_LEDS));

  // Byte for the current phase
  always_comb begin
    unique case (phase_r[3:2])
      SEG_START: cur_byte = START_BYTE;
      SEG_LED: begin
        unique case (phase_r[1:0])
          LED_HDR:   cur_byte = {HEADER_BITS, bright_r};
          LED_BLUE:  cur_byte = blue_r;
          LED_GREEN: cur_byte = green_r;
          LED_RED:   cur_byte = red_r;
          default:   cur_byte = START_BYTE;
        endcase
      end
      SEG_END:   cur_byte = END_BYTE;
      default:   cur_byte = START_BYTE;
    endcase
  end

  // Item / sequencer next state
  always_comb begin
    item_vld_nxt = item_vld_r;
    phase_nxt    = phase_r;
    led_idx_nxt  = led_idx_r;
    if (item_adv) begin
      if (item_last) begin
        item_vld_nxt = 1'b0;
      end else begin
        phase_nxt = phase_r + PHASE_W'(1);
      end
    end
    if (in_acc) begin
      item_vld_nxt = 1'b1;
      // start burst only on the first LED of a frame
      phase_nxt    = (led_idx_r == '0) ? PH_FIRST_START : PH_FIRST_LED;
      led_idx_nxt  = acc_ends ? '0 : led_next[INDEX_W-1:0];
    end
  end

  assign out_vld_nxt = out_ready ? item_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r   <= BRIGHT_RST;
      item_vld_r <= 1'b0;
      phase_r    <= PH_FIRST_START;
      led_idx_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bright_r <= cfg_wr_data;
      end
      item_vld_r <= item_vld_nxt;
      phase_r    <= phase_nxt;
      led_idx_r  <= led_idx_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      ends_r  <= acc_ends;
    end
    if (item_adv) begin
      out_byte_r <= cur_byte;
      out_last_r <= item_last;
      out_fend_r <= cur_fend;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte         = out_byte_r;
  assign out_last_of_item = out_last_r;
  assign out_frame_end    = out_fend_r;

endmodule

FILE: hdl/lsfe_checker.sv
// Port-level checks for the LED strip frame encoder, bound to the top level.
`timescale 1ns / 1ps

module lsfe_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lsfe_pkg::byte_t     out_byte,
  input logic                out_last_of_item,
  input logic                out_frame_end
);
  import lsfe_pkg::*;

  // End of frame always closes the transaction that caused it
  a_fend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_last_of_item)
    else $error("frame_end without last_of_item");

  // Final end-frame byte is all ones
  a_fend_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_byte == END_BYTE)
    else $error("frame_end on a byte other than the end pattern");

  // A byte following a frame end starts a new frame with a zero start byte
  a_start_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_frame_end ##1 out_valid |-> out_byte == START_BYTE)
    else $error("new frame does not open with a start byte");

  // Output empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind led_strip_frame_encoder_core lsfe_checker u_lsfe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_byte         (out_byte),
  .out_last_of_item (out_last_of_item),
  .out_frame_end    (out_frame_end)
);
